>>> rtl/gmt_pkg.sv
// ----------------------------------------------------------------------------
// gmt_pkg
// Shared types and constants of the gossip membership table: operation codes
// and the request packet that walks down the row of slot cells.
// ----------------------------------------------------------------------------
package gmt_pkg;

	// slot index and member count widths cover the largest table (1024 slots)
	localparam int SLOT_W = 10;
	localparam int CNT_W  = 11;

	// fan-out divide by three: n/3 = (n * RECIP3) >> RECIP_SH for n < 2**CNT_W
	localparam int RECIP_SH = CNT_W + 1;
	localparam int RECIP3   = (2 ** RECIP_SH + 2) / 3;

	localparam int IN_DATA_W  = 120;
	localparam int OUT_DATA_W = 136;

	typedef enum logic [1:0] {
		FN_MERGE = 2'd0,
		FN_TICK  = 2'd1,
		FN_SELF  = 2'd2,
		FN_READ  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		REG_OWN_ID    = 2'd0,
		REG_OWN_PORT  = 2'd1,
		REG_FAIL_TIME = 2'd2
	} reg_idx_t;

	// request packet handed from cell to cell
	typedef struct packed {
		func_t              func;
		logic               second;
		logic [31:0]        eid;
		logic [15:0]        eport;
		logic [31:0]        ehb;
		logic [5:0]         sidx;
		logic [31:0]        now;
		logic [16:0]        limit;
		logic [31:0]        own_id;
		logic [15:0]        own_port;
		logic [31:0]        own_hb;
		logic [SLOT_W-1:0]  own_slot;
		logic               found;
		logic               refreshed;
		logic               inserted;
		logic               taken;
		logic               own_hit;
		logic [SLOT_W-1:0]  new_own;
		logic               live;
		logic [31:0]        rid;
		logic [15:0]        rport;
		logic [31:0]        rhb;
		logic [31:0]        rstamp;
		logic [CNT_W-1:0]   cnt;
		logic [CNT_W-1:0]   ev;
	} pkt_t;

endpackage

>>> rtl/gmt_cell.sv
// ----------------------------------------------------------------------------
// gmt_cell
// One table slot. Holds the slot contents, acts on the request packet as it
// passes and hands the updated packet to the next cell in the next cycle.
// ----------------------------------------------------------------------------
module gmt_cell #(
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  gmt_pkg::pkt_t in_pkt,
	output logic          out_vld,
	output gmt_pkg::pkt_t out_pkt
);

	logic                v_q;
	logic [31:0]         id_q;
	logic [15:0]         port_q;
	logic [31:0]         hb_q;
	logic [31:0]         st_q;
	logic                vld_q;
	gmt_pkg::pkt_t       pkt_q;

	gmt_pkg::pkt_t       nxt;
	logic                w_en;
	logic                w_v;
	logic [31:0]         w_id;
	logic [15:0]         w_port;
	logic [31:0]         w_hb;
	logic [31:0]         w_st;
	logic                hit_e;
	logic                hit_o;
	logic                fill;
	logic                post_v;
	logic [31:0]         post_id;
	logic [31:0]         stamp_t;
	logic [31:0]         age;
	logic                own_here;
	logic                rd_here;

	assign hit_e    = v_q && (id_q == in_pkt.eid);
	assign hit_o    = v_q && (id_q == in_pkt.own_id);
	assign own_here = (in_pkt.own_slot == gmt_pkg::SLOT_W'(IDX));
	assign rd_here  = (IDX < 64) && (in_pkt.sidx == 6'(IDX));

	// slot action for the passing request
	always_comb begin
		nxt     = in_pkt;
		w_en    = 1'b0;
		w_v     = v_q;
		w_id    = id_q;
		w_port  = port_q;
		w_hb    = hb_q;
		w_st    = st_q;
		fill    = 1'b0;
		post_v  = v_q;
		post_id = id_q;
		stamp_t = (v_q && own_here) ? in_pkt.now : st_q;
		age     = (in_pkt.now >= stamp_t) ? in_pkt.now - stamp_t : stamp_t - in_pkt.now;
		if (!in_pkt.second) begin
			unique case (in_pkt.func)
				gmt_pkg::FN_MERGE: begin
					if (hit_e) begin
						nxt.found = 1'b1;
						if (in_pkt.ehb > hb_q) begin
							w_en          = 1'b1;
							w_port        = in_pkt.eport;
							w_hb          = in_pkt.ehb;
							w_st          = in_pkt.now;
							nxt.refreshed = 1'b1;
						end
					end
				end
				gmt_pkg::FN_TICK: begin
					if (v_q) begin
						w_en = 1'b1;
						if (own_here) begin
							w_hb = in_pkt.own_hb;
							w_st = in_pkt.now;
						end
						if (age >= {15'd0, in_pkt.limit}) begin
							w_v    = 1'b0;
							nxt.ev = in_pkt.ev + gmt_pkg::CNT_W'(1);
						end
					end
				end
				gmt_pkg::FN_SELF: begin
					if (hit_o && !in_pkt.found) begin
						w_en        = 1'b1;
						w_port      = in_pkt.own_port;
						w_hb        = in_pkt.own_hb;
						w_st        = in_pkt.now;
						nxt.found   = 1'b1;
						nxt.own_hit = 1'b1;
						nxt.new_own = gmt_pkg::SLOT_W'(IDX);
					end
				end
				gmt_pkg::FN_READ: begin
					if (rd_here && v_q) begin
						nxt.live   = 1'b1;
						nxt.rid    = id_q;
						nxt.rport  = port_q;
						nxt.rhb    = hb_q;
						nxt.rstamp = st_q;
					end
				end
				default: ;
			endcase
		end else begin
			// second pass: insert into the lowest free slot, then count
			fill = !v_q && !in_pkt.found && !in_pkt.taken &&
				((in_pkt.func == gmt_pkg::FN_MERGE) || (in_pkt.func == gmt_pkg::FN_SELF));
			if (fill) begin
				w_en         = 1'b1;
				w_v          = 1'b1;
				nxt.taken    = 1'b1;
				nxt.inserted = 1'b1;
				if (in_pkt.func == gmt_pkg::FN_MERGE) begin
					w_id   = in_pkt.eid;
					w_port = in_pkt.eport;
					w_hb   = in_pkt.ehb;
				end else begin
					w_id        = in_pkt.own_id;
					w_port      = in_pkt.own_port;
					w_hb        = in_pkt.own_hb;
					nxt.own_hit = 1'b1;
					nxt.new_own = gmt_pkg::SLOT_W'(IDX);
				end
				w_st = in_pkt.now;
			end
			post_v  = v_q || fill;
			post_id = fill ? w_id : id_q;
			// own slot follows the lowest slot holding own id after a merge
			if ((in_pkt.func == gmt_pkg::FN_MERGE) && post_v &&
				(post_id == in_pkt.own_id) && !in_pkt.own_hit) begin
				nxt.own_hit = 1'b1;
				nxt.new_own = gmt_pkg::SLOT_W'(IDX);
			end
			nxt.cnt = in_pkt.cnt + gmt_pkg::CNT_W'(post_v);
		end
	end

	// slot valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_vld && w_en) begin
			v_q <= w_v;
		end
	end

	// slot contents
	always_ff @(posedge clk) begin
		if (in_vld && w_en) begin
			id_q   <= w_id;
			port_q <= w_port;
			hb_q   <= w_hb;
			st_q   <= w_st;
		end
	end

	// hand the request to the neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_vld) begin
			pkt_q <= nxt;
		end
	end

	assign out_vld = vld_q;
	assign out_pkt = pkt_q;

endmodule

>>> rtl/gossip_membership_table.sv
// ----------------------------------------------------------------------------
// gossip_membership_table
// Gossip heartbeat membership table built as a row of slot cells.
// ----------------------------------------------------------------------------
// Each request walks the row of MAX_MEMBERS slot cells twice, one cell per
// cycle: the first pass matches ids, refreshes, ages and evicts, and reads a
// slot; the second inserts into the lowest free slot and counts members. The
// finished request is registered in the result register, then moved into the
// output register; only then can the next request be taken, so one request is
// in flight at a time. A finished result waits in the output register without
// holding up the next request; a second finished result waits until that
// register is free. The table comes out of reset empty, with no clearing pass.
module gossip_membership_table #(
	parameter int MAX_MEMBERS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// config write port
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_addr,
	input  logic [31:0]                     cfg_wdata,
	// request stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// entry_id, entry_port, entry_heartbeat, slot_index, now, zero pad
	input  logic [gmt_pkg::IN_DATA_W-1:0]   s_tdata,
	// func
	input  logic [1:0]                      s_tuser,
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// slot_live, found, inserted, refreshed, table_full, out_id, out_port,
	// out_heartbeat, out_stamp, member_count, fanout, evicted_count
	output logic [gmt_pkg::OUT_DATA_W-1:0]  m_tdata
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} state_t;

	state_t                       state_q;
	logic [31:0]                  own_id_q;
	logic [15:0]                  own_port_q;
	logic [15:0]                  fail_time_q;
	logic [31:0]                  own_hb_q;
	logic [gmt_pkg::SLOT_W-1:0]   own_slot_q;
	gmt_pkg::pkt_t                res_q;
	logic                         m_tvalid_q;
	logic [gmt_pkg::OUT_DATA_W-1:0] m_tdata_q;

	logic                         chain_vld [MAX_MEMBERS+1];
	gmt_pkg::pkt_t                chain_pkt [MAX_MEMBERS+1];
	logic                         accept;
	logic                         end_vld;
	gmt_pkg::pkt_t                end_pkt;
	gmt_pkg::pkt_t                fresh;
	gmt_pkg::pkt_t                again;
	logic                         out_free;
	logic [2*gmt_pkg::CNT_W-1:0]  prod;
	logic [4:0]                   fanout;
	logic                         full;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign end_vld  = chain_vld[MAX_MEMBERS];
	assign end_pkt  = chain_pkt[MAX_MEMBERS];
	assign out_free = !m_tvalid_q || m_tready;

	// fresh request packet
	always_comb begin
		fresh          = '0;
		fresh.func     = gmt_pkg::func_t'(s_tuser);
		fresh.eid      = s_tdata[31:0];
		fresh.eport    = s_tdata[47:32];
		fresh.ehb      = s_tdata[79:48];
		fresh.sidx     = s_tdata[85:80];
		fresh.now      = s_tdata[117:86];
		fresh.limit    = {fail_time_q, 1'b0};
		fresh.own_id   = own_id_q;
		fresh.own_port = own_port_q;
		fresh.own_hb   = (fresh.func == gmt_pkg::FN_TICK) ? own_hb_q + 32'd1 : own_hb_q;
		fresh.own_slot = own_slot_q;
		again          = end_pkt;
		again.second   = 1'b1;
		again.cnt      = '0;
	end

	// head of the row: new request or its second pass
	assign chain_vld[0] = accept || (end_vld && !end_pkt.second);
	assign chain_pkt[0] = accept ? fresh : again;

	for (genvar g = 0; g < MAX_MEMBERS; g++) begin : g_cell
		gmt_cell #(.IDX(g)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_vld  (chain_vld[g]),
			.in_pkt  (chain_pkt[g]),
			.out_vld (chain_vld[g+1]),
			.out_pkt (chain_pkt[g+1])
		);
	end

	// fan-out from the final member count, reported on tick only
	assign prod   = {{gmt_pkg::CNT_W{1'b0}}, res_q.cnt} *
		(2*gmt_pkg::CNT_W)'(gmt_pkg::RECIP3);
	assign fanout = ((res_q.func != gmt_pkg::FN_TICK) ||
		(res_q.cnt <= gmt_pkg::CNT_W'(1))) ? 5'd0 :
		5'(prod[2*gmt_pkg::CNT_W-1:gmt_pkg::RECIP_SH]) + 5'd1;
	assign full   = ((res_q.func == gmt_pkg::FN_MERGE) || (res_q.func == gmt_pkg::FN_SELF)) &&
		!res_q.found && !res_q.taken;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q    <= '0;
			own_port_q  <= '0;
			fail_time_q <= 16'd5;
		end else if (cfg_we) begin
			unique case (gmt_pkg::reg_idx_t'(cfg_addr))
				gmt_pkg::REG_OWN_ID:    own_id_q    <= cfg_wdata;
				gmt_pkg::REG_OWN_PORT:  own_port_q  <= cfg_wdata[15:0];
				gmt_pkg::REG_FAIL_TIME: fail_time_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// sequencer, own state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			own_hb_q   <= '0;
			own_slot_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// output valid: load a finished result or drop once taken
			if (state_q == ST_HOLD && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q  <= ST_RUN;
						own_hb_q <= fresh.own_hb;
					end
				end
				ST_RUN: begin
					if (end_vld && end_pkt.second) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (res_q.own_hit) begin
							own_slot_q <= res_q.new_own;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// finished request and packed result
	always_ff @(posedge clk) begin
		if (state_q == ST_RUN && end_vld && end_pkt.second) begin
			res_q <= end_pkt;
		end
		if (state_q == ST_HOLD && out_free) begin
			m_tdata_q <= {7'(res_q.ev), fanout, 7'(res_q.cnt), res_q.rstamp, res_q.rhb,
				res_q.rport, res_q.rid, full, res_q.refreshed, res_q.inserted,
				res_q.found, res_q.live};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> rtl/gmt_checker.sv
// ----------------------------------------------------------------------------
// gmt_checker
// Port-level checks of the membership table, bound to the top level.
// ----------------------------------------------------------------------------
module gmt_checker #(
	parameter int MAX_MEMBERS = 64
) (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [135:0] m_tdata
);

	// one request in flight: ready drops right after a request is taken
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while previous still in flight");

	// result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed while stalled");

	// outcome flags of a merge or set self are exclusive
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[2] && m_tdata[4]) && !(m_tdata[1] && m_tdata[2]) &&
			!(m_tdata[1] && m_tdata[4]))
		else $error("conflicting found, inserted and table_full");

	// fan-out is zero with one member or none
	a_fanout: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[123:117] <= 7'd1) |-> (m_tdata[128:124] == 5'd0))
		else $error("fan-out reported with at most one member");

endmodule

bind gossip_membership_table gmt_checker #(.MAX_MEMBERS(MAX_MEMBERS)) u_gmt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
